@@ sv/cfd_pkg.sv @@
// Shared constants and types for the control frame deframer.
package cfd_pkg;

  localparam logic [7:0]  HDR_D          = 8'h44;
  localparam logic [7:0]  HDR_S          = 8'h53;
  localparam logic [15:0] COUNT_MAX      = 16'hffff;
  localparam logic [15:0] MIN_LEN_RESET  = 16'd14;
  localparam int          CFG_ADDR_W     = 3;
  localparam int          CFG_DATA_W     = 32;

  // Byte offsets inside a frame
  localparam logic [15:0] POS_HDR0       = 16'd0;
  localparam logic [15:0] POS_HDR1       = 16'd1;
  localparam logic [15:0] POS_HDR2       = 16'd2;
  localparam logic [15:0] POS_HDR3       = 16'd3;
  localparam logic [15:0] POS_TYPE       = 16'd4;
  localparam logic [15:0] POS_LEN_HI     = 16'd5;
  localparam logic [15:0] POS_LEN_LO     = 16'd6;
  localparam logic [15:0] POS_PAYLOAD_A  = 16'd11;
  localparam logic [15:0] POS_PAYLOAD_B  = 16'd12;
  localparam logic [15:0] HDR_BYTES      = 16'd4;

  // Register word index
  localparam logic REG_MIN_LEN = 1'b0;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_HDR  = 2'd1,
    STATUS_BAD_LEN  = 2'd2,
    STATUS_BAD_CSUM = 2'd3
  } frame_status_t;

endpackage

@@ sv/cfd_regs.sv @@
// Configuration register file with its APB-style access port.
module cfd_regs
  import cfd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  output logic [15:0]           min_len
);

  logic [15:0] min_len_r;
  logic [15:0] min_len_nxt;
  logic        wr_en;

  // Complete a write in the access phase
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    min_len_nxt = min_len_r;
    if (wr_en && (cfg_paddr[CFG_ADDR_W-1] == REG_MIN_LEN)) begin
      min_len_nxt = cfg_pwdata[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= MIN_LEN_RESET;
    end else begin
      min_len_r <= min_len_nxt;
    end
  end

  // Return the register on reads, zero elsewhere
  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[CFG_ADDR_W-1] == REG_MIN_LEN) begin
      cfg_prdata = {{(CFG_DATA_W-16){1'b0}}, min_len_r};
    end
  end

  assign cfg_pready = 1'b1;
  assign min_len    = min_len_r;

endmodule

@@ sv/control_frame_deframer.sv @@
// Top level: byte-wise control frame checker with registered result.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+---------------------------------
//  in_      | input     | in_valid / in_ready    | rx_byte, end_of_frame
//  out_     | output    | out_valid / out_ready  | status, type fields, payload
//  cfg_     | input     | APB psel/penable       | min_frame_length at offset 0
//
// One byte is taken per cycle while in_ready is high; frame state updates at the accepting edge.
// The final byte's result is captured into the output register at the edge that accepts it.
// A byte that is not the last is taken even while a result waits; a last
// byte waits only while the output register is full and not being drained.
// Synchronous active-low reset clears frame state and the output valid.
module control_frame_deframer
  import cfd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_rx_byte,
  input  logic                  in_end_of_frame,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_frame_status,
  output logic [2:0]            out_message_kind,
  output logic [2:0]            out_data_kind,
  output logic [1:0]            out_device_kind,
  output logic [7:0]            out_payload_first,
  output logic [7:0]            out_payload_second,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic [15:0]   min_len;

  logic [15:0]   byte_count_r,  byte_count_nxt;
  logic [7:0]    sum_r,         sum_nxt;
  logic          hdr_good_r,    hdr_good_nxt;
  logic [7:0]    type_r,        type_nxt;
  logic [15:0]   decl_len_r,    decl_len_nxt;
  logic [7:0]    pay_a_r,       pay_a_nxt;
  logic [7:0]    pay_b_r,       pay_b_nxt;

  logic          out_valid_r,   out_valid_nxt;
  frame_status_t status_r,      status_nxt;
  logic [7:0]    res_type_r;
  logic [7:0]    res_pay_a_r;
  logic [7:0]    res_pay_b_r;

  logic          in_fire;
  logic          last_fire;
  logic [15:0]   cnt_sat;

  cfd_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .min_len     (min_len)
  );

  // Stall only a final byte, and only while the result slot stays full
  assign in_ready  = !in_end_of_frame || !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign last_fire = in_fire && in_end_of_frame;

  // Advance the byte counter, holding at its top value
  assign cnt_sat = (byte_count_r == COUNT_MAX) ? byte_count_r : byte_count_r + 16'd1;

  // Capture header, type, length and payload fields by position
  always_comb begin
    hdr_good_nxt = hdr_good_r;
    type_nxt     = type_r;
    decl_len_nxt = decl_len_r;
    pay_a_nxt    = pay_a_r;
    pay_b_nxt    = pay_b_r;
    unique case (byte_count_r)
      POS_HDR0, POS_HDR2: begin
        if (in_rx_byte != HDR_D) hdr_good_nxt = 1'b0;
      end
      POS_HDR1, POS_HDR3: begin
        if (in_rx_byte != HDR_S) hdr_good_nxt = 1'b0;
      end
      POS_TYPE:      type_nxt            = in_rx_byte;
      POS_LEN_HI:    decl_len_nxt[15:8]  = in_rx_byte;
      POS_LEN_LO:    decl_len_nxt[7:0]   = in_rx_byte;
      POS_PAYLOAD_A: pay_a_nxt           = in_rx_byte;
      POS_PAYLOAD_B: pay_b_nxt           = in_rx_byte;
      default: ;
    endcase
  end

  // Judge header, then length, then checksum
  always_comb begin
    if (!hdr_good_nxt || (cnt_sat < HDR_BYTES)) begin
      status_nxt = STATUS_BAD_HDR;
    end else if ((cnt_sat < min_len) || (cnt_sat != decl_len_nxt)) begin
      status_nxt = STATUS_BAD_LEN;
    end else if (sum_r != in_rx_byte) begin
      status_nxt = STATUS_BAD_CSUM;
    end else begin
      status_nxt = STATUS_OK;
    end
  end

  assign sum_nxt        = sum_r + in_rx_byte;
  assign byte_count_nxt = cnt_sat;

  // Update frame state; drop it back to reset after the final byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      sum_r        <= '0;
      hdr_good_r   <= 1'b1;
      type_r       <= '0;
      decl_len_r   <= '0;
      pay_a_r      <= '0;
      pay_b_r      <= '0;
    end else if (last_fire) begin
      byte_count_r <= '0;
      sum_r        <= '0;
      hdr_good_r   <= 1'b1;
      type_r       <= '0;
      decl_len_r   <= '0;
      pay_a_r      <= '0;
      pay_b_r      <= '0;
    end else if (in_fire) begin
      byte_count_r <= byte_count_nxt;
      sum_r        <= sum_nxt;
      hdr_good_r   <= hdr_good_nxt;
      type_r       <= type_nxt;
      decl_len_r   <= decl_len_nxt;
      pay_a_r      <= pay_a_nxt;
      pay_b_r      <= pay_b_nxt;
    end
  end

  // Hold the result until the output transaction completes
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (last_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (last_fire) begin
      status_r    <= status_nxt;
      res_type_r  <= type_nxt;
      res_pay_a_r <= pay_a_nxt;
      res_pay_b_r <= pay_b_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_frame_status   = status_r;
  assign out_message_kind   = res_type_r[7:5];
  assign out_data_kind      = res_type_r[4:2];
  assign out_device_kind    = res_type_r[1:0];
  assign out_payload_first  = res_pay_a_r;
  assign out_payload_second = res_pay_b_r;

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the control frame deframer.
`timescale 1ns / 1ps

module tb_top;
  import cfd_pkg::*;

  localparam int LIMIT_CYCLES = 40000;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES = 150;
  localparam int PRINT_CAP = 40;
  localparam logic [CFG_ADDR_W-1:0] MIN_LEN_ADDR = {REG_MIN_LEN, 2'b00};

  typedef logic [7:0] byte_q_t[$];

  typedef enum int {
    FLAW_NONE,
    FLAW_HEADER,
    FLAW_LENGTH,
    FLAW_CSUM,
    FLAW_SHORT,
    FLAW_NOISE
  } frame_flaw_t;

  typedef struct packed {
    frame_status_t status;
    logic [2:0]    msg_kind;
    logic [2:0]    data_kind;
    logic [1:0]    dev_kind;
    logic [7:0]    pay_a;
    logic [7:0]    pay_b;
  } frame_report_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            in_rx_byte = 8'h00;
  logic                  in_end_of_frame = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [1:0]            out_frame_status;
  logic [2:0]            out_message_kind;
  logic [2:0]            out_data_kind;
  logic [1:0]            out_device_kind;
  logic [7:0]            out_payload_first;
  logic [7:0]            out_payload_second;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // Frame tracker state, mirrors the block
  logic [15:0] min_len = MIN_LEN_RESET;
  logic [15:0] fr_count = '0;
  logic [7:0]  fr_sum = '0;
  logic        fr_hdr_ok = 1'b1;
  logic [7:0]  fr_type = '0;
  logic [15:0] fr_len = '0;
  logic [7:0]  fr_pay_a = '0;
  logic [7:0]  fr_pay_b = '0;

  frame_report_t pending_reports[$];

  int error_count = 0;
  int bytes_sent = 0;
  int frames_sent = 0;
  int status_seen[4] = '{0, 0, 0, 0};
  int cycle_count = 0;
  int hold_left = 0;
  int stall_left = 0;
  bit calm = 1'b0;

  control_frame_deframer uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_rx_byte         (in_rx_byte),
    .in_end_of_frame    (in_end_of_frame),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_frame_status   (out_frame_status),
    .out_message_kind   (out_message_kind),
    .out_data_kind      (out_data_kind),
    .out_device_kind    (out_device_kind),
    .out_payload_first  (out_payload_first),
    .out_payload_second (out_payload_second),
    .cfg_psel           (cfg_psel),
    .cfg_penable        (cfg_penable),
    .cfg_pwrite         (cfg_pwrite),
    .cfg_paddr          (cfg_paddr),
    .cfg_pwdata         (cfg_pwdata),
    .cfg_prdata         (cfg_prdata),
    .cfg_pready         (cfg_pready)
  );

  always #1 clk = ~clk;

  // Count cycles and abort a hung run
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("control_frame_deframer: mismatch");
    $finish;
  end

  task automatic flag_error(input string msg);
    if (error_count < PRINT_CAP) $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Advance the frame tracker by one accepted byte; queue a report on the last one
  function automatic void track_frame_byte(input logic [7:0] b, input logic last);
    frame_report_t rep;
    case (fr_count)
      POS_HDR0, POS_HDR2: if (b != HDR_D) fr_hdr_ok = 1'b0;
      POS_HDR1, POS_HDR3: if (b != HDR_S) fr_hdr_ok = 1'b0;
      POS_TYPE:           fr_type = b;
      POS_LEN_HI:         fr_len[15:8] = b;
      POS_LEN_LO:         fr_len[7:0] = b;
      POS_PAYLOAD_A:      fr_pay_a = b;
      POS_PAYLOAD_B:      fr_pay_b = b;
      default: ;
    endcase
    if (fr_count != COUNT_MAX) fr_count++;
    if (!last) begin
      fr_sum += b;
      return;
    end
    // Header beats length, length beats checksum
    if (!fr_hdr_ok || fr_count < HDR_BYTES) rep.status = STATUS_BAD_HDR;
    else if (fr_count < min_len || fr_count != fr_len) rep.status = STATUS_BAD_LEN;
    else if (fr_sum != b) rep.status = STATUS_BAD_CSUM;
    else rep.status = STATUS_OK;
    rep.msg_kind  = fr_type[7:5];
    rep.data_kind = fr_type[4:2];
    rep.dev_kind  = fr_type[1:0];
    rep.pay_a     = fr_pay_a;
    rep.pay_b     = fr_pay_b;
    pending_reports.push_back(rep);
    fr_count  = '0;
    fr_sum    = '0;
    fr_hdr_ok = 1'b1;
    fr_type   = '0;
    fr_len    = '0;
    fr_pay_a  = '0;
    fr_pay_b  = '0;
  endfunction

  // Compare each output transaction with the oldest pending report
  always @(posedge clk) begin : check_results
    frame_report_t want;
    frame_report_t got;
    if (rst_n && out_valid && out_ready) begin
      got.status    = frame_status_t'(out_frame_status);
      got.msg_kind  = out_message_kind;
      got.data_kind = out_data_kind;
      got.dev_kind  = out_device_kind;
      got.pay_a     = out_payload_first;
      got.pay_b     = out_payload_second;
      if (pending_reports.size() == 0) begin
        flag_error("result transaction with no frame pending");
      end else begin
        want = pending_reports.pop_front();
        status_seen[want.status]++;
        if (got !== want) begin
          flag_error($sformatf({"got st=%0d msg=%0d dat=%0d dev=%0d p=%02h/%02h, ",
                                "want st=%0d msg=%0d dat=%0d dev=%0d p=%02h/%02h"},
                               got.status, got.msg_kind, got.data_kind, got.dev_kind,
                               got.pay_a, got.pay_b, want.status, want.msg_kind,
                               want.data_kind, want.dev_kind, want.pay_a, want.pay_b));
        end
      end
    end
  end

  // Drive out_ready: long hold when asked, always ready when calm, else short random stall bursts
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 4) == 0) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(1, 3) - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Send one byte; called and returns at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_rx_byte      <= b;
    in_end_of_frame <= last;
    do @(posedge clk); while (!in_ready);
    track_frame_byte(b, last);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(input byte_q_t fb);
    foreach (fb[i]) send_byte(fb[i], i == fb.size() - 1);
    frames_sent++;
  endtask

  // Drop valid, wait for all reports, then let the pipeline drain
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [CFG_DATA_W-1:0] wdata,
                            output logic [CFG_DATA_W-1:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= MIN_LEN_ADDR;
    cfg_pwdata  <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic check_min_length();
    logic [CFG_DATA_W-1:0] rd;
    apb_access(1'b0, '0, rd);
    if (rd[15:0] !== min_len)
      flag_error($sformatf("min length reads %0d, want %0d", rd[15:0], min_len));
  endtask

  // Write the minimum length while idle and read it back
  task automatic set_min_length(input logic [15:0] value);
    logic [CFG_DATA_W-1:0] rd;
    apb_access(1'b1, CFG_DATA_W'(value), rd);
    min_len = value;
    check_min_length();
  endtask

  function automatic byte_q_t with_checksum(input byte_q_t fb);
    logic [7:0] sum;
    sum = '0;
    foreach (fb[i]) sum += fb[i];
    fb.push_back(sum);
    return fb;
  endfunction

  // Build a frame of len bytes, well formed except for the chosen flaw
  function automatic byte_q_t make_frame(input int len, input frame_flaw_t flaw);
    byte_q_t fb;
    logic [15:0] decl;
    int pick;
    fb = {};
    if (flaw == FLAW_NOISE) begin
      repeat (len) fb.push_back(8'($urandom));
      return fb;
    end
    decl = (len > int'(COUNT_MAX)) ? COUNT_MAX : 16'(len);
    if (flaw == FLAW_LENGTH) decl = decl + 16'($urandom_range(1, 65535));
    fb = {HDR_D, HDR_S, HDR_D, HDR_S, 8'($urandom), decl[15:8], decl[7:0]};
    if (flaw == FLAW_SHORT) begin
      while (fb.size() > len) void'(fb.pop_back());
      return fb;
    end
    while (fb.size() < len - 1) fb.push_back(8'($urandom));
    if (flaw == FLAW_HEADER) begin
      pick = $urandom_range(0, 3);
      fb[pick] ^= 8'(1 << $urandom_range(0, 7));
    end
    fb = with_checksum(fb);
    if (flaw == FLAW_CSUM) fb[fb.size() - 1] ^= 8'($urandom_range(1, 255));
    return fb;
  endfunction

  task automatic test_register_reset();
    check_min_length();
  endtask

  // Single byte, truncated header, header only, and a clean minimum frame
  task automatic test_directed_frames();
    byte_q_t fb;
    fb = {8'hFF};
    send_frame(fb);
    fb = {HDR_D, HDR_S, HDR_D};
    send_frame(fb);
    fb = {HDR_D, HDR_S, HDR_D, HDR_S};
    send_frame(fb);
    fb = {HDR_D, HDR_S, HDR_D, HDR_S, 8'hFF, 8'h00, 8'd14,
          8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00};
    send_frame(with_checksum(fb));
  endtask

  // Mostly well-formed frames with random content, the rest broken or noise
  task automatic test_random_frames(input int budget);
    int stop_at;
    int len;
    int r;
    frame_flaw_t flaw;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 60) flaw = FLAW_NONE;
      else if (r < 68) flaw = FLAW_HEADER;
      else if (r < 76) flaw = FLAW_LENGTH;
      else if (r < 84) flaw = FLAW_CSUM;
      else if (r < 92) flaw = FLAW_SHORT;
      else flaw = FLAW_NOISE;
      case ($urandom_range(0, 3))
        0:       len = int'(min_len);
        1:       len = int'(min_len) - 1;
        default: len = $urandom_range(8, 40);
      endcase
      if (len < 8) len = 8;
      if (len > 64) len = 64;
      if (flaw == FLAW_SHORT) len = $urandom_range(1, 7);
      if (flaw == FLAW_NOISE) len = $urandom_range(1, 20);
      send_frame(make_frame(len, flaw));
    end
  endtask

  // Sweep the minimum length from zero up to its top value
  task automatic test_length_extremes();
    set_min_length(16'd0);
    test_random_frames(250);
    settle();
    set_min_length(16'($urandom_range(8, 30)));
    test_random_frames(250);
    settle();
    set_min_length(16'hFFFF);
    test_random_frames(60);
    settle();
  endtask

  // Hold the output off while single-byte frames keep coming
  task automatic test_output_backpressure();
    byte_q_t fb;
    set_min_length(MIN_LEN_RESET);
    hold_left = HOLD_CYCLES;
    repeat (12) begin
      fb = {8'($urandom)};
      send_frame(fb);
    end
    test_random_frames(40);
    settle();
  endtask

  task automatic test_steady_stream();
    calm = 1'b1;
    test_random_frames(150);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_register_reset();
    test_directed_frames();
    test_random_frames(250);
    settle();
    test_length_extremes();
    test_output_backpressure();
    test_steady_stream();
    settle();

    $display("Sent %0d bytes in %0d frames; reports ok/header/length/checksum %0d/%0d/%0d/%0d",
             bytes_sent, frames_sent, status_seen[STATUS_OK], status_seen[STATUS_BAD_HDR],
             status_seen[STATUS_BAD_LEN], status_seen[STATUS_BAD_CSUM]);
    $display("Min length swept over 14, 0, random, 65535; output held off for a long stretch");
    if (error_count == 0) begin
      $display("control_frame_deframer: match");
    end else begin
      $display("control_frame_deframer: mismatch");
    end
    $finish;
  end

endmodule
